// ===== src/pixel_mask_sprite_collision_macros.svh =====
// assertion macros for the sprite collision block
// used by the controller and datapath files, no other dependencies
`ifndef PIXEL_MASK_SPRITE_COLLISION_MACROS_SVH
`define PIXEL_MASK_SPRITE_COLLISION_MACROS_SVH

`ifndef SYNTHESIS
// checked property, skipped while reset is high
`define PMSC_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("pmsc check failed");
// checked property, also checked during reset
`define PMSC_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("pmsc check failed");
`else
`define PMSC_ASSERT(lbl, clk, rst, prop)
`define PMSC_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// ===== src/pmsc_pkg.sv =====
// shared types and constants for the sprite collision block
// no dependencies
package pmsc_pkg;

  localparam int COORD_W = 18;   // signed screen coordinate after origin subtract
  localparam int IN_DATA_W = 88;
  localparam int IN_USER_W = 2;
  localparam int OUT_DATA_W = 8;
  localparam int CFG_IDX_W = 4;
  localparam int CFG_DATA_W = 8;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH_A    = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT_A   = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_A_X = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_A_Y = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH_B    = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT_B   = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_B_X = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_B_Y = 4'd7;

  // operation codes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TEST = 1'b1;

  // sprite select codes
  localparam logic SEL_A = 1'b0;
  localparam logic SEL_B = 1'b1;

  typedef struct packed {
    logic capture;
    logic load_rd;
    logic load_wr;
    logic calc1;
    logic calc2;
    logic calc3;
    logic calc4;
    logic scan_rd;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic overlap;
    logic scan_last;
  } status_t;

endpackage

// ===== src/pixel_mask_sprite_collision.sv =====
// top level of the pixel-exact sprite collision checker
// depends on pmsc_pkg, pmsc_ctrl and pmsc_datapath
//
// Two sprites keep one-bit opacity masks of MAX_HEIGHT rows by MAX_WIDTH
// columns; a load beat (tuser bit 0 low) writes one pixel, opaque when alpha
// is nonzero, and gives no result; a load reads the pixel's row, patches it
// and writes it back to the selected mask.
// A test beat forms both bounding boxes from position minus origin and the
// configured size (saturated at the mask size) and returns one result beat.
// With disjoint boxes, or an overlap with no pixel in it, no row is
// scanned; otherwise the overlap rows are scanned one per cycle, each cycle
// reading one row word from each mask. The finished result waits in the
// output register while the next beat is taken.
// Masks read transparent after reset through per-row valid bits, so there is
// no clearing pass. Config writes are taken every cycle and must only be
// issued while the block is idle.
module pixel_mask_sprite_collision #(
  parameter int MAX_WIDTH = 64,
  parameter int MAX_HEIGHT = 64
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // pixel_x[5:0], pixel_y[11:6], alpha[19:12], pos_a_x[35:20],
  // pos_a_y[51:36], pos_b_x[67:52], pos_b_y[83:68], zeros above
  input  logic [pmsc_pkg::IN_DATA_W-1:0]    s_tdata,
  // operation[0], sprite_select[1]
  input  logic [pmsc_pkg::IN_USER_W-1:0]    s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // boxes_overlap[0], collided[1], zeros above
  output logic [pmsc_pkg::OUT_DATA_W-1:0]   m_tdata,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [pmsc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pmsc_pkg::CFG_DATA_W-1:0]   cfg_data
);

  pmsc_pkg::cmd_t    cmd;
  pmsc_pkg::status_t status;

  assign cfg_ready = 1'b1;

  pmsc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_op    (s_tuser[0]),
    .in_ready (s_tready),
    .out_valid(m_tvalid),
    .out_ready(m_tready),
    .status   (status),
    .cmd      (cmd)
  );

  pmsc_datapath #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .in_data  (s_tdata),
    .in_user  (s_tuser),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .cmd      (cmd),
    .status   (status),
    .out_data (m_tdata)
  );

endmodule

// ===== src/pmsc_mask.sv =====
// one sprite opacity mask: a row-wide memory with a valid bit per row
// uses no package items
module pmsc_mask #(
  parameter int MAX_WIDTH = 64,
  parameter int MAX_HEIGHT = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [$clog2(MAX_HEIGHT)-1:0] rd_addr,
  output logic [MAX_WIDTH-1:0]          rd_row,
  input  logic                          wr_en,
  input  logic [$clog2(MAX_HEIGHT)-1:0] wr_addr,
  input  logic [MAX_WIDTH-1:0]          wr_row
);

  logic [MAX_WIDTH-1:0]  mem [MAX_HEIGHT];
  logic [MAX_HEIGHT-1:0] row_valid;
  logic [MAX_WIDTH-1:0]  rd_data;
  logic                  rd_valid;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_row;
    end
    rd_data <= mem[rd_addr];
  end

  // rows never written read as transparent
  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
      rd_valid  <= 1'b0;
    end else begin
      if (wr_en) begin
        row_valid[wr_addr] <= 1'b1;
      end
      rd_valid <= row_valid[rd_addr];
    end
  end

  assign rd_row = rd_valid ? rd_data : '0;

endmodule

// ===== src/pmsc_datapath.sv =====
// datapath: config registers, box arithmetic, row scan and result register
// depends on pmsc_pkg, pmsc_mask and the assertion macro header
`include "pixel_mask_sprite_collision_macros.svh"

module pmsc_datapath #(
  parameter int MAX_WIDTH = 64,
  parameter int MAX_HEIGHT = 64
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [pmsc_pkg::IN_DATA_W-1:0]    in_data,
  input  logic [pmsc_pkg::IN_USER_W-1:0]    in_user,
  input  logic                              cfg_we,
  input  logic [pmsc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pmsc_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  pmsc_pkg::cmd_t                    cmd,
  output pmsc_pkg::status_t                 status,
  output logic [pmsc_pkg::OUT_DATA_W-1:0]   out_data
);

  localparam int CW  = pmsc_pkg::COORD_W;
  localparam int RAW = $clog2(MAX_HEIGHT);
  localparam int CAW = $clog2(MAX_WIDTH);
  localparam int LXW = $clog2(MAX_WIDTH + 1);
  localparam int LYW = $clog2(MAX_HEIGHT + 1);

  // config registers
  logic [6:0] width_a, height_a, width_b, height_b;
  logic [5:0] origin_a_x, origin_a_y, origin_b_x, origin_b_y;

  // captured item
  logic               sel;
  logic [5:0]         px, py;
  logic [7:0]         alpha;
  logic signed [15:0] pos_a_x, pos_a_y, pos_b_x, pos_b_y;

  // box arithmetic
  logic signed [CW-1:0] ax, ay, bx, by;
  logic signed [CW-1:0] ea, fa, eb, fb;
  logic signed [CW-1:0] x0, x1, y0, y1;
  logic signed [CW-1:0] wa, ha, wb, hb;
  logic                 overlap;

  // scan state
  logic [CAW-1:0] shift_a, shift_b;
  logic [LXW-1:0] len_x;
  logic [RAW-1:0] row_a, row_b;
  logic [LYW-1:0] rows_left;
  logic           eval_pend;
  logic           hit;

  logic           res_overlap, res_hit;

  logic [RAW-1:0]       rd_addr_a, rd_addr_b, ld_row;
  logic [CAW-1:0]       ld_col;
  logic [MAX_WIDTH-1:0] rd_row_a, rd_row_b, row_mod, len_mask;
  logic                 in_range, row_hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      width_a    <= 7'd64;
      height_a   <= 7'd64;
      origin_a_x <= '0;
      origin_a_y <= '0;
      width_b    <= 7'd64;
      height_b   <= 7'd64;
      origin_b_x <= '0;
      origin_b_y <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pmsc_pkg::REG_WIDTH_A:    width_a    <= cfg_data[6:0];
        pmsc_pkg::REG_HEIGHT_A:   height_a   <= cfg_data[6:0];
        pmsc_pkg::REG_ORIGIN_A_X: origin_a_x <= cfg_data[5:0];
        pmsc_pkg::REG_ORIGIN_A_Y: origin_a_y <= cfg_data[5:0];
        pmsc_pkg::REG_WIDTH_B:    width_b    <= cfg_data[6:0];
        pmsc_pkg::REG_HEIGHT_B:   height_b   <= cfg_data[6:0];
        pmsc_pkg::REG_ORIGIN_B_X: origin_b_x <= cfg_data[5:0];
        pmsc_pkg::REG_ORIGIN_B_Y: origin_b_y <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  // sizes saturate at the mask dimensions
  always_comb begin
    wa = (CW'(width_a) > CW'(MAX_WIDTH)) ? CW'(MAX_WIDTH) : CW'(width_a);
    ha = (CW'(height_a) > CW'(MAX_HEIGHT)) ? CW'(MAX_HEIGHT) : CW'(height_a);
    wb = (CW'(width_b) > CW'(MAX_WIDTH)) ? CW'(MAX_WIDTH) : CW'(width_b);
    hb = (CW'(height_b) > CW'(MAX_HEIGHT)) ? CW'(MAX_HEIGHT) : CW'(height_b);
  end

  // item capture and box arithmetic, one step per command
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      sel     <= in_user[1];
      px      <= in_data[5:0];
      py      <= in_data[11:6];
      alpha   <= in_data[19:12];
      pos_a_x <= in_data[35:20];
      pos_a_y <= in_data[51:36];
      pos_b_x <= in_data[67:52];
      pos_b_y <= in_data[83:68];
    end
    if (cmd.calc1) begin
      ax <= CW'(pos_a_x) - CW'(origin_a_x);
      ay <= CW'(pos_a_y) - CW'(origin_a_y);
      bx <= CW'(pos_b_x) - CW'(origin_b_x);
      by <= CW'(pos_b_y) - CW'(origin_b_y);
    end
    if (cmd.calc2) begin
      ea <= ax + wa;
      fa <= ay + ha;
      eb <= bx + wb;
      fb <= by + hb;
    end
    if (cmd.calc3) begin
      overlap <= (ax < eb) && (bx < ea) && (ay < fb) && (by < fa);
      x0      <= (ax > bx) ? ax : bx;
      y0      <= (ay > by) ? ay : by;
      x1      <= (ea < eb) ? ea : eb;
      y1      <= (fa < fb) ? fa : fb;
    end
    if (cmd.calc4) begin
      shift_a <= CAW'(x0 - ax);
      shift_b <= CAW'(x0 - bx);
      len_x   <= LXW'(x1 - x0);
    end
  end

  // row counters for the scan
  always_ff @(posedge clk) begin
    if (rst) begin
      rows_left <= '0;
      eval_pend <= 1'b0;
      hit       <= 1'b0;
    end else begin
      eval_pend <= cmd.scan_rd;
      if (cmd.calc4) begin
        row_a     <= RAW'(y0 - ay);
        row_b     <= RAW'(y0 - by);
        rows_left <= LYW'(y1 - y0);
      end else if (cmd.scan_rd) begin
        row_a     <= row_a + RAW'(1);
        row_b     <= row_b + RAW'(1);
        rows_left <= rows_left - LYW'(1);
      end
      if (cmd.calc1) begin
        hit <= 1'b0;
      end else if (eval_pend && row_hit) begin
        hit <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      res_overlap <= overlap;
      res_hit     <= hit & overlap;
    end
  end

  // memory addressing and load read-modify-write
  always_comb begin
    ld_row    = RAW'(py);
    ld_col    = CAW'(px);
    in_range  = (32'(px) < MAX_WIDTH) && (32'(py) < MAX_HEIGHT);
    rd_addr_a = cmd.load_rd ? ld_row : row_a;
    rd_addr_b = cmd.load_rd ? ld_row : row_b;
    row_mod   = (sel == pmsc_pkg::SEL_B) ? rd_row_b : rd_row_a;
    row_mod[ld_col] = (alpha != 8'd0);
  end

  // overlap columns of both rows line up at bit 0 after the shifts
  always_comb begin
    len_mask = ~({MAX_WIDTH{1'b1}} << len_x);
    row_hit  = |((rd_row_a >> shift_a) & (rd_row_b >> shift_b) & len_mask);
  end

  pmsc_mask #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_mask_a (
    .clk    (clk),
    .rst    (rst),
    .rd_addr(rd_addr_a),
    .rd_row (rd_row_a),
    .wr_en  (cmd.load_wr && in_range && (sel == pmsc_pkg::SEL_A)),
    .wr_addr(ld_row),
    .wr_row (row_mod)
  );

  pmsc_mask #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_mask_b (
    .clk    (clk),
    .rst    (rst),
    .rd_addr(rd_addr_b),
    .rd_row (rd_row_b),
    .wr_en  (cmd.load_wr && in_range && (sel == pmsc_pkg::SEL_B)),
    .wr_addr(ld_row),
    .wr_row (row_mod)
  );

  // a zero-size box can overlap with no pixel in common, then there is nothing to scan
  assign status.overlap   = overlap && (x1 > x0) && (y1 > y0);
  assign status.scan_last = (rows_left == LYW'(1));
  assign out_data = {6'b0, res_hit, res_overlap};

  `PMSC_ASSERT(a_scan_has_rows, clk, rst, cmd.scan_rd |-> (rows_left != '0))
  `PMSC_ASSERT(a_overlap_rows, clk, rst, (cmd.calc4 && status.overlap) |=> (rows_left != '0))
  `PMSC_ASSERT(a_one_shift_zero, clk, rst,
    (cmd.calc4 && overlap) |=> (shift_a == '0 || shift_b == '0))

endmodule

// ===== src/pmsc_ctrl.sv =====
// controller state machine: sequences loads, box math and the row scan
// depends on pmsc_pkg and the assertion macro header
`include "pixel_mask_sprite_collision_macros.svh"

module pmsc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_op,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  pmsc_pkg::status_t status,
  output pmsc_pkg::cmd_t    cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_LD_RD,
    S_LD_WR,
    S_CALC1,
    S_CALC2,
    S_CALC3,
    S_CALC4,
    S_SCAN,
    S_FLUSH,
    S_DONE
  } state_t;

  state_t state;
  logic   out_free;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd          = '0;
    cmd.capture  = in_ready && in_valid;
    cmd.load_rd  = (state == S_LD_RD);
    cmd.load_wr  = (state == S_LD_WR);
    cmd.calc1    = (state == S_CALC1);
    cmd.calc2    = (state == S_CALC2);
    cmd.calc3    = (state == S_CALC3);
    cmd.calc4    = (state == S_CALC4);
    cmd.scan_rd  = (state == S_SCAN);
    cmd.out_load = (state == S_DONE) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= (in_op == pmsc_pkg::OP_TEST) ? S_CALC1 : S_LD_RD;
          end
        end
        S_LD_RD: state <= S_LD_WR;
        S_LD_WR: state <= S_IDLE;
        S_CALC1: state <= S_CALC2;
        S_CALC2: state <= S_CALC3;
        S_CALC3: state <= S_CALC4;
        S_CALC4: state <= status.overlap ? S_SCAN : S_DONE;
        S_SCAN: begin
          if (status.scan_last) begin
            state <= S_FLUSH;
          end
        end
        // last row's data is evaluated here
        S_FLUSH: state <= S_DONE;
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `PMSC_ASSERT(a_done_presents, clk, rst, cmd.out_load |=> out_valid)
  `PMSC_ASSERT(a_result_from_done, clk, rst, $rose(out_valid) |-> $past(state) == S_DONE)
  `PMSC_ASSERT_ALWAYS(a_no_result_in_reset, clk, rst |=> !out_valid)

endmodule

// ===== tb/sv/tb_pixel_mask_sprite_collision.sv =====
// self-checking testbench for the pixel-exact sprite collision block
// drives mask loads and collision tests, predicts each result from its own copy of the masks
// depends on pmsc_pkg and pixel_mask_sprite_collision
module tb_pixel_mask_sprite_collision;

  localparam int MASK_W = 64;
  localparam int MASK_H = 64;
  localparam int SETTLE_CYCLES = 80;    // a full 64-row scan plus the fixed test overhead
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int RANDOM_PHASES = 7;
  localparam int PHASE_BEATS = 250;
  localparam int MAX_REPORTS = 10;

  typedef struct {
    logic        op;
    logic        sel;
    logic [5:0]  px;
    logic [5:0]  py;
    logic [7:0]  alpha;
    logic [15:0] pax;
    logic [15:0] pay;
    logic [15:0] pbx;
    logic [15:0] pby;
  } sprite_beat_t;

  typedef struct {
    logic overlap;
    logic hit;
  } hit_result_t;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            s_tvalid = 1'b0;
  logic                            s_tready;
  logic [pmsc_pkg::IN_DATA_W-1:0]  s_tdata = '0;
  logic [pmsc_pkg::IN_USER_W-1:0]  s_tuser = '0;
  logic                            m_tvalid;
  logic                            m_tready = 1'b0;
  logic [pmsc_pkg::OUT_DATA_W-1:0] m_tdata;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [pmsc_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [pmsc_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  // predictor copy of the block state
  logic [MASK_W-1:0] mask_a [MASK_H];
  logic [MASK_W-1:0] mask_b [MASK_H];
  int                sprite_reg [8];

  sprite_beat_t stim_beats [$];
  hit_result_t  pending_results [$];

  logic in_fire = 1'b0;
  logic out_fire = 1'b0;
  logic cfg_fire = 1'b0;
  int   send_gap = 0;
  bit   send_idle_on = 1'b1;
  int   recv_stall = 0;
  bit   recv_idle_on = 1'b1;
  int   beats_queued = 0;
  int   beats_taken = 0;
  int   results_seen = 0;
  int   mismatches = 0;
  int   idle_cycles = 0;
  int   load_count = 0;
  int   test_count = 0;
  int   overlap_count = 0;
  int   hit_count = 0;
  int   reg_writes = 0;

  pixel_mask_sprite_collision dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int clamp_size(int v, int max_v);
    return (v > max_v) ? max_v : v;
  endfunction

  function automatic hit_result_t collision_predict(logic [15:0] pax, logic [15:0] pay,
                                                    logic [15:0] pbx, logic [15:0] pby);
    int ax, ay, bx, by, wa, ha, wb, hb, x0, y0, x1, y1;
    hit_result_t r;
    ax = int'($signed(pax)) - sprite_reg[pmsc_pkg::REG_ORIGIN_A_X];
    ay = int'($signed(pay)) - sprite_reg[pmsc_pkg::REG_ORIGIN_A_Y];
    bx = int'($signed(pbx)) - sprite_reg[pmsc_pkg::REG_ORIGIN_B_X];
    by = int'($signed(pby)) - sprite_reg[pmsc_pkg::REG_ORIGIN_B_Y];
    wa = clamp_size(sprite_reg[pmsc_pkg::REG_WIDTH_A], MASK_W);
    ha = clamp_size(sprite_reg[pmsc_pkg::REG_HEIGHT_A], MASK_H);
    wb = clamp_size(sprite_reg[pmsc_pkg::REG_WIDTH_B], MASK_W);
    hb = clamp_size(sprite_reg[pmsc_pkg::REG_HEIGHT_B], MASK_H);
    // edges that only touch do not count
    r.overlap = (ax < bx + wb) && (bx < ax + wa) && (ay < by + hb) && (by < ay + ha);
    r.hit = 1'b0;
    if (r.overlap) begin
      x0 = (ax > bx) ? ax : bx;
      y0 = (ay > by) ? ay : by;
      x1 = (ax + wa < bx + wb) ? ax + wa : bx + wb;
      y1 = (ay + ha < by + hb) ? ay + ha : by + hb;
      for (int y = y0; y < y1 && !r.hit; y++)
        for (int x = x0; x < x1; x++)
          if (mask_a[y - ay][x - ax] && mask_b[y - by][x - bx]) r.hit = 1'b1;
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, int want, int got);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("mismatch at result %0d: %s expected %0d got %0d", results_seen, what, want, got);
  endtask

  // monitor: predictor update on input beats, result check on output beats, watchdog
  always @(posedge clk) begin
    hit_result_t want;
    in_fire <= !rst && s_tvalid && s_tready;
    out_fire <= !rst && m_tvalid && m_tready;
    cfg_fire <= !rst && cfg_valid && cfg_ready;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          report_mismatch("result beat with nothing pending, data", 0, int'(m_tdata));
        end else begin
          want = pending_results.pop_front();
          if (m_tdata[0] !== want.overlap)
            report_mismatch("boxes_overlap", want.overlap, m_tdata[0]);
          if (m_tdata[1] !== want.hit)
            report_mismatch("collided", want.hit, m_tdata[1]);
        end
      end
      if (s_tvalid && s_tready) begin
        beats_taken++;
        if (s_tuser[0] == pmsc_pkg::OP_LOAD) begin
          load_count++;
          if (s_tuser[1] == pmsc_pkg::SEL_A)
            mask_a[s_tdata[11:6]][s_tdata[5:0]] = (s_tdata[19:12] != 0);
          else
            mask_b[s_tdata[11:6]][s_tdata[5:0]] = (s_tdata[19:12] != 0);
        end else begin
          want = collision_predict(s_tdata[35:20], s_tdata[51:36], s_tdata[67:52],
                                   s_tdata[83:68]);
          pending_results.push_back(want);
          test_count++;
          if (want.overlap) overlap_count++;
          if (want.hit) hit_count++;
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          pmsc_pkg::REG_WIDTH_A, pmsc_pkg::REG_HEIGHT_A,
          pmsc_pkg::REG_WIDTH_B, pmsc_pkg::REG_HEIGHT_B:
            sprite_reg[cfg_index] = int'(cfg_data[6:0]);
          pmsc_pkg::REG_ORIGIN_A_X, pmsc_pkg::REG_ORIGIN_A_Y,
          pmsc_pkg::REG_ORIGIN_B_X, pmsc_pkg::REG_ORIGIN_B_Y:
            sprite_reg[cfg_index] = int'(cfg_data[5:0]);
          default: ;
        endcase
      end
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
          $display("timeout: no beat moved for %0d cycles, %0d results pending",
                   idle_cycles, pending_results.size());
          $display("tb_pixel_mask_sprite_collision: FAIL");
          $finish;
        end
      end
    end
  end

  // input driver: one beat at a time from stim_beats, random gap after each beat
  always @(negedge clk) begin
    sprite_beat_t b;
    if (rst) begin
      s_tvalid <= 1'b0;
      send_gap <= 0;
    end else if (!s_tvalid || in_fire) begin
      if (send_gap > 0) begin
        s_tvalid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (stim_beats.size() > 0) begin
        b = stim_beats.pop_front();
        s_tvalid <= 1'b1;
        s_tuser <= {b.sel, b.op};
        s_tdata <= {4'b0, b.pby, b.pbx, b.pay, b.pax, b.alpha, b.py, b.px};
        if ($urandom_range(0, 63) == 0) send_idle_on = !send_idle_on;
        send_gap <= send_idle_on ? int'($urandom_range(0, 15)) : 0;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // result receiver: stalls after results and at random points
  always @(negedge clk) begin
    int d;
    if (rst) begin
      m_tready <= 1'b0;
      recv_stall = 0;
    end else if (recv_stall > 0) begin
      m_tready <= 1'b0;
      recv_stall--;
    end else begin
      if ($urandom_range(0, 63) == 0) recv_idle_on = !recv_idle_on;
      d = (recv_idle_on && (out_fire || $urandom_range(0, 7) == 0)) ?
          int'($urandom_range(0, 15)) : 0;
      if (d > 0) begin
        m_tready <= 1'b0;
        recv_stall = d - 1;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  function automatic sprite_beat_t load_beat(logic sel, int x, int y, int alpha);
    sprite_beat_t b;
    b.op = pmsc_pkg::OP_LOAD;
    b.sel = sel;
    b.px = 6'(x);
    b.py = 6'(y);
    b.alpha = 8'(alpha);
    // positions are don't-care on a load
    b.pax = 16'($urandom);
    b.pay = 16'($urandom);
    b.pbx = 16'($urandom);
    b.pby = 16'($urandom);
    return b;
  endfunction

  function automatic sprite_beat_t test_beat(int ax, int ay, int bx, int by);
    sprite_beat_t b;
    b.op = pmsc_pkg::OP_TEST;
    b.sel = 1'($urandom);
    b.px = 6'($urandom);
    b.py = 6'($urandom);
    b.alpha = 8'($urandom);
    b.pax = 16'(ax);
    b.pay = 16'(ay);
    b.pbx = 16'(bx);
    b.pby = 16'(by);
    return b;
  endfunction

  task automatic queue_beat(sprite_beat_t b);
    stim_beats.push_back(b);
    beats_queued++;
  endtask

  task automatic write_reg(logic [pmsc_pkg::CFG_IDX_W-1:0] idx,
                           logic [pmsc_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(negedge clk); while (!cfg_fire);
    cfg_valid <= 1'b0;
    reg_writes++;
  endtask

  task automatic write_all_regs(logic [pmsc_pkg::CFG_DATA_W-1:0] plan [8]);
    for (int i = pmsc_pkg::REG_WIDTH_A; i <= pmsc_pkg::REG_ORIGIN_B_Y; i++)
      write_reg(pmsc_pkg::CFG_IDX_W'(i), plan[i]);
    // indexes past the last register must be ignored
    write_reg(pmsc_pkg::CFG_IDX_W'(pmsc_pkg::REG_ORIGIN_B_Y + 1 + $urandom_range(0, 7)),
              8'($urandom));
  endtask

  // wait until every pending result is back, then let any trailing load finish
  task automatic wait_idle();
    do @(negedge clk); while (beats_taken != beats_queued || pending_results.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  function automatic logic [7:0] pick_size();
    logic [7:0] v;
    v = 8'($urandom_range(1, 64));
    if ($urandom_range(0, 9) == 0) v = 8'($urandom_range(65, 127));
    if ($urandom_range(0, 14) == 0) v = 8'd0;
    v[7] = 1'($urandom);
    return v;
  endfunction

  function automatic int near_pos();
    if ($urandom_range(0, 9) == 0)
      return $urandom_range(0, 1) ? 32767 - int'($urandom_range(0, 80)) :
                                    -32768 + int'($urandom_range(0, 80));
    return int'($urandom_range(0, 400)) - 200;
  endfunction

  task automatic queue_random_phase(int count);
    int wa, ha, wb, hb, w, h, ax, ay, bx, by, alpha;
    logic sel;
    wa = clamp_size(sprite_reg[pmsc_pkg::REG_WIDTH_A], MASK_W);
    ha = clamp_size(sprite_reg[pmsc_pkg::REG_HEIGHT_A], MASK_H);
    wb = clamp_size(sprite_reg[pmsc_pkg::REG_WIDTH_B], MASK_W);
    hb = clamp_size(sprite_reg[pmsc_pkg::REG_HEIGHT_B], MASK_H);
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 99) < 55) begin
        sel = 1'($urandom);
        w = (sel == pmsc_pkg::SEL_A) ? wa : wb;
        h = (sel == pmsc_pkg::SEL_A) ? ha : hb;
        // mostly pixels inside the live box so the tests can find them
        if (w == 0 || h == 0 || $urandom_range(0, 7) == 0) begin
          w = MASK_W;
          h = MASK_H;
        end
        alpha = ($urandom_range(0, 2) == 0) ? 0 : int'($urandom_range(1, 255));
        queue_beat(load_beat(sel, $urandom_range(0, w - 1), $urandom_range(0, h - 1), alpha));
      end else if ($urandom_range(0, 7) == 0) begin
        queue_beat(test_beat($urandom, $urandom, $urandom, $urandom));
      end else begin
        ax = near_pos();
        ay = near_pos();
        // place box B around box A, from just clear on one side to just clear on the other
        bx = ax - sprite_reg[pmsc_pkg::REG_ORIGIN_A_X] + sprite_reg[pmsc_pkg::REG_ORIGIN_B_X]
             + int'($urandom_range(0, wa + wb + 4)) - wb - 2;
        by = ay - sprite_reg[pmsc_pkg::REG_ORIGIN_A_Y] + sprite_reg[pmsc_pkg::REG_ORIGIN_B_Y]
             + int'($urandom_range(0, ha + hb + 4)) - hb - 2;
        queue_beat(test_beat(ax, ay, bx, by));
      end
    end
  endtask

  initial begin
    logic [pmsc_pkg::CFG_DATA_W-1:0] plan [8];
    for (int r = 0; r < MASK_H; r++) begin
      mask_a[r] = '0;
      mask_b[r] = '0;
    end
    sprite_reg[pmsc_pkg::REG_WIDTH_A] = 64;
    sprite_reg[pmsc_pkg::REG_HEIGHT_A] = 64;
    sprite_reg[pmsc_pkg::REG_ORIGIN_A_X] = 0;
    sprite_reg[pmsc_pkg::REG_ORIGIN_A_Y] = 0;
    sprite_reg[pmsc_pkg::REG_WIDTH_B] = 64;
    sprite_reg[pmsc_pkg::REG_HEIGHT_B] = 64;
    sprite_reg[pmsc_pkg::REG_ORIGIN_B_X] = 0;
    sprite_reg[pmsc_pkg::REG_ORIGIN_B_Y] = 0;
    repeat (4) @(negedge clk);
    rst <= 1'b0;

    // directed checks at the reset configuration
    @(posedge clk);
    queue_beat(test_beat(0, 0, 0, 0));
    queue_beat(load_beat(pmsc_pkg::SEL_A, 0, 0, 255));
    queue_beat(load_beat(pmsc_pkg::SEL_B, 63, 63, 1));
    queue_beat(test_beat(0, 0, -63, -63));
    queue_beat(test_beat(0, 0, 64, 0));
    queue_beat(test_beat(0, 0, 0, -64));
    queue_beat(test_beat(0, 0, 63, 63));
    queue_beat(load_beat(pmsc_pkg::SEL_A, 0, 0, 0));
    queue_beat(test_beat(0, 0, -63, -63));
    queue_beat(load_beat(pmsc_pkg::SEL_A, 0, 0, 128));
    queue_beat(load_beat(pmsc_pkg::SEL_B, 0, 0, 255));
    queue_beat(test_beat(-32768, -32768, 32767, 32767));
    queue_beat(test_beat(32767, 32767, 32767, 32767));
    queue_beat(test_beat(-32768, -32768, -32768, -32768));
    wait_idle();

    // zero width on A, oversized height on B, origin A x and origin B y at their top
    plan[pmsc_pkg::REG_WIDTH_A] = 8'h80;
    plan[pmsc_pkg::REG_HEIGHT_A] = 8'd64;
    plan[pmsc_pkg::REG_ORIGIN_A_X] = 8'hFF;
    plan[pmsc_pkg::REG_ORIGIN_A_Y] = 8'd0;
    plan[pmsc_pkg::REG_WIDTH_B] = 8'd64;
    plan[pmsc_pkg::REG_HEIGHT_B] = 8'hFF;
    plan[pmsc_pkg::REG_ORIGIN_B_X] = 8'd0;
    plan[pmsc_pkg::REG_ORIGIN_B_Y] = 8'd63;
    write_all_regs(plan);
    @(posedge clk);
    queue_beat(test_beat(0, 0, 0, 0));
    queue_beat(test_beat(63, 0, 0, 63));
    wait_idle();

    // oversized width on A saturates to the mask width
    write_reg(pmsc_pkg::REG_WIDTH_A, 8'hFF);
    @(posedge clk);
    queue_beat(test_beat(63, 0, 0, 63));
    queue_beat(test_beat(63, 0, 64, 63));
    wait_idle();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      for (int i = pmsc_pkg::REG_WIDTH_A; i <= pmsc_pkg::REG_ORIGIN_B_Y; i++) begin
        if (i == pmsc_pkg::REG_ORIGIN_A_X || i == pmsc_pkg::REG_ORIGIN_A_Y ||
            i == pmsc_pkg::REG_ORIGIN_B_X || i == pmsc_pkg::REG_ORIGIN_B_Y)
          plan[i] = (p == 0) ? 8'd63 : (p == 1) ? 8'd0 : 8'($urandom);
        else
          plan[i] = (p == 0) ? 8'd64 : (p == 1) ? 8'd1 : pick_size();
      end
      write_all_regs(plan);
      @(posedge clk);
      queue_random_phase(PHASE_BEATS);
      wait_idle();
    end

    $display("run covered %0d mask loads and %0d collision tests (%0d box overlaps, %0d hits)",
             load_count, test_count, overlap_count, hit_count);
    $display("%0d register writes, %0d results checked, %0d mismatches, %0d left pending",
             reg_writes, results_seen, mismatches, pending_results.size());
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("tb_pixel_mask_sprite_collision: PASS");
    end else begin
      $display("tb_pixel_mask_sprite_collision: FAIL");
    end
    $finish;
  end

endmodule
